// ===== rtl/send_queue_ack_retry_assert.svh =====
// assertion macros for the send queue with ack retry
`ifndef SEND_QUEUE_ACK_RETRY_ASSERT_SVH
`define SEND_QUEUE_ACK_RETRY_ASSERT_SVH

`ifndef SYNTHESIS
`define SQAR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqar assertion failed");
`define SQAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqar assertion failed");
`else
`define SQAR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SQAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/sqar_pkg.sv =====
// constants and codes for the send queue with ack retry
`timescale 1ns / 1ps
package sqar_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 8;
  localparam int unsigned DEF_HANDLE_BITS = 8;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned ATTEMPT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_ENQUEUE   = 2'd0;
  localparam logic [OP_W-1:0] OP_SEND_DONE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK      = 2'd2;

  localparam logic [CODE_W-1:0] RES_OK      = 2'd0;
  localparam logic [CODE_W-1:0] RES_FULL    = 2'd1;
  localparam logic [CODE_W-1:0] RES_ABANDON = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'b1;

  localparam logic [TIMEOUT_W-1:0] RST_ACK_TIMEOUT  = 16'd5;
  localparam logic [ATTEMPT_W-1:0] RST_MAX_ATTEMPTS = 4'd3;

endpackage

// ===== rtl/sqar_handle_mem.sv =====
// frame handle queue storage, one write and one registered read port
`timescale 1ns / 1ps
module sqar_handle_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/send_queue_ack_retry.sv =====
// top level of the stop-and-wait transmit queue with ack timeout and retry
//
// Events come in on the s_axis channel (enqueue, send done, timer tick) and
// every event produces exactly one status beat on the m_axis channel, which
// says whether a frame must go out now, whether it is a retry, the result
// code, the queue level and whether an ack is awaited.
// Each event passes through the accept state, which updates pointers and
// counters and reads the handle memory, and then the finish state, which takes
// the registered read data and loads the status beat into the output register.
// No new event is taken while the finish state handles the last one; the next
// event is accepted once that register is empty or draining. A handle written
// and read in the same cycle is forwarded.
// The two configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i and must only change while the block is idle.
// Reset empties the queue, clears counters and the waiting state and loads
// the default timeout of 5 ticks and 3 attempts; the memory is not cleared.
// A stalled m_axis_tready holds the status beat and blocks new events.
`timescale 1ns / 1ps
`include "send_queue_ack_retry_assert.svh"
module send_queue_ack_retry #(
  parameter int unsigned QUEUE_DEPTH = sqar_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned HANDLE_BITS = sqar_pkg::DEF_HANDLE_BITS,
  localparam int unsigned LW  = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned S_W = ((sqar_pkg::OP_W + HANDLE_BITS + 7) / 8) * 8,
  localparam int unsigned M_W = ((HANDLE_BITS + LW + 5 + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sqar_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sqar_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // operation, frame_handle
  input  logic [S_W-1:0]                   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // send_valid, send_frame, is_resend, result_code, queue_level, awaiting_ack
  output logic [M_W-1:0]                   m_axis_tdata
);

  import sqar_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned HB = HANDLE_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_LVL = LW'(QUEUE_DEPTH);

  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_FINISH = 1'b1;

  logic state_q, state_d;

  logic [TIMEOUT_W-1:0] timeout_q;
  logic [ATTEMPT_W-1:0] max_att_q;

  logic [IW-1:0] rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic          rd_wrap_q, rd_wrap_d, wr_wrap_q, wr_wrap_d;
  logic          wait_q, wait_d;
  logic [ATTEMPT_W-1:0] att_q, att_d;
  logic [TIMEOUT_W-1:0] tc_q, tc_d;
  logic [HB-1:0] cur_q;

  logic          sent_q, sent_d, resend_q, resend_d, load_q, load_d, fwd_q;
  logic [CODE_W-1:0] code_q, code_d;
  logic [HB-1:0] fwd_data_q;

  logic          m_valid_q;
  logic          out_sent_q, out_resend_q, out_wait_q;
  logic [HB-1:0] out_frame_q;
  logic [CODE_W-1:0] out_code_q;
  logic [LW-1:0] out_level_q;

  logic          accept, start, mem_we, mem_re;
  logic [OP_W-1:0] op;
  logic [HB-1:0] handle, mem_rdata, frame_now;
  logic [LW-1:0] level;
  logic [TIMEOUT_W-1:0] limit, tc_inc;
  logic [ATTEMPT_W-1:0] tries;
  logic          timed_out;

  assign op     = s_axis_tdata[OP_W-1:0];
  assign handle = s_axis_tdata[OP_W +: HB];

  assign s_axis_tready = (state_q == ST_ACCEPT) && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign level = (wr_wrap_q != rd_wrap_q) ? DEPTH_LVL + LW'(wr_idx_q) - LW'(rd_idx_q)
                                          : LW'(wr_idx_q) - LW'(rd_idx_q);

  assign limit     = (timeout_q == '0) ? TIMEOUT_W'(1) : timeout_q;
  assign tries     = (max_att_q == '0) ? ATTEMPT_W'(1) : max_att_q;
  assign tc_inc    = (tc_q < limit) ? tc_q + 1'b1 : tc_q;
  assign timed_out = (tc_inc >= limit);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= RST_ACK_TIMEOUT;
      max_att_q <= RST_MAX_ATTEMPTS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_TIMEOUT:  timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        CFG_MAX_ATTEMPTS: max_att_q <= cfg_data_i[ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  // event decode and queue update
  always_comb begin
    rd_idx_d  = rd_idx_q;
    rd_wrap_d = rd_wrap_q;
    wr_idx_d  = wr_idx_q;
    wr_wrap_d = wr_wrap_q;
    wait_d    = wait_q;
    att_d     = att_q;
    tc_d      = tc_q;
    sent_d    = 1'b0;
    resend_d  = 1'b0;
    load_d    = 1'b0;
    code_d    = RES_OK;
    mem_we    = 1'b0;
    start     = 1'b0;
    if (accept) begin
      case (op)
        OP_ENQUEUE: begin
          if (level >= DEPTH_LVL) begin
            rd_idx_d  = wr_idx_q;
            rd_wrap_d = wr_wrap_q;
            wait_d    = 1'b0;
            att_d     = '0;
            tc_d      = '0;
            code_d    = RES_FULL;
          end else begin
            mem_we    = 1'b1;
            wr_idx_d  = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
            wr_wrap_d = (wr_idx_q == LAST_IDX) ? ~wr_wrap_q : wr_wrap_q;
            start     = !wait_q;
          end
        end
        OP_SEND_DONE: begin
          if (level != '0) begin
            start = 1'b1;
          end else begin
            wait_d = 1'b0;
          end
        end
        OP_TICK: begin
          if (wait_q) begin
            tc_d = tc_inc;
            if (timed_out) begin
              if (att_q < tries) begin
                att_d    = att_q + 1'b1;
                tc_d     = '0;
                sent_d   = 1'b1;
                resend_d = 1'b1;
              end else begin
                code_d = RES_ABANDON;
                if (level != '0) begin
                  start = 1'b1;
                end else begin
                  wait_d = 1'b0;
                  att_d  = '0;
                  tc_d   = '0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (start) begin
      rd_idx_d  = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
      rd_wrap_d = (rd_idx_q == LAST_IDX) ? ~rd_wrap_q : rd_wrap_q;
      wait_d    = 1'b1;
      att_d     = ATTEMPT_W'(1);
      tc_d      = '0;
      sent_d    = 1'b1;
      load_d    = 1'b1;
    end
  end

  assign mem_re = start;

  sqar_handle_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (HB)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx_q),
    .wdata_i (handle),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (mem_rdata)
  );

  assign state_d = accept ? ST_FINISH : ST_ACCEPT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ACCEPT;
      rd_idx_q  <= '0;
      rd_wrap_q <= 1'b0;
      wr_idx_q  <= '0;
      wr_wrap_q <= 1'b0;
      wait_q    <= 1'b0;
      att_q     <= '0;
      tc_q      <= '0;
      sent_q    <= 1'b0;
      resend_q  <= 1'b0;
      load_q    <= 1'b0;
      fwd_q     <= 1'b0;
      code_q    <= RES_OK;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      rd_wrap_q <= rd_wrap_d;
      wr_idx_q  <= wr_idx_d;
      wr_wrap_q <= wr_wrap_d;
      wait_q    <= wait_d;
      att_q     <= att_d;
      tc_q      <= tc_d;
      if (accept) begin
        sent_q   <= sent_d;
        resend_q <= resend_d;
        load_q   <= load_d;
        code_q   <= code_d;
        fwd_q    <= mem_we && start && (rd_idx_q == wr_idx_q);
      end
    end
  end

  // write-to-read forwarding data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= handle;
    end
  end

  assign frame_now = load_q ? (fwd_q ? fwd_data_q : mem_rdata) : cur_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH) begin
      cur_q        <= frame_now;
      out_sent_q   <= sent_q;
      out_frame_q  <= sent_q ? frame_now : '0;
      out_resend_q <= resend_q;
      out_code_q   <= code_q;
      out_level_q  <= level;
      out_wait_q   <= wait_q;
    end
  end

  // status beat output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_W'({out_wait_q, out_level_q, out_code_q, out_resend_q,
                               out_frame_q, out_sent_q});

  `SQAR_ASSERT_NEXT(a_accept_finish, clk_i, rst_ni, accept, state_q == ST_FINISH)
  `SQAR_ASSERT_NEXT(a_finish_beat, clk_i, rst_ni, state_q == ST_FINISH, m_valid_q)
  `SQAR_ASSERT_NOW(a_level_bound, clk_i, rst_ni, 1'b1, level <= DEPTH_LVL)
  `SQAR_ASSERT_NOW(a_wait_attempt, clk_i, rst_ni, wait_q, att_q != '0)

endmodule

// ===== verif/sqar_status_checker.sv =====
// status beat checker for the send queue with ack retry
`timescale 1ns / 1ps
module sqar_status_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sqar_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sqar_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [23:0]                     m_axis_tdata,
  output int                              err_cnt_o,
  output int                              pending_o,
  output int                              beats_o,
  output int                              retries_o,
  output int                              abandons_o,
  output int                              overflows_o
);

  import sqar_pkg::*;

  typedef struct {
    logic       send_valid;
    logic [7:0] send_frame;
    logic       is_resend;
    logic [1:0] result_code;
    logic [3:0] queue_level;
    logic       awaiting_ack;
  } status_t;

  status_t status_due[$];

  logic [7:0]  slots [8];
  logic [3:0]  rd_ptr, wr_ptr;
  logic [7:0]  cur_frame;
  logic        busy;
  logic [3:0]  tries_done;
  logic [15:0] ticks;
  logic [15:0] timeout_cfg;
  logic [3:0]  attempts_cfg;

  function automatic bit launch_next();
    if (wr_ptr != rd_ptr) begin
      cur_frame  = slots[rd_ptr[2:0]];
      rd_ptr     = rd_ptr + 4'd1;
      busy       = 1'b1;
      tries_done = 4'd1;
      ticks      = '0;
      return 1'b1;
    end
    busy = 1'b0;
    return 1'b0;
  endfunction

  function automatic status_t advance_link_state(logic [OP_W-1:0] op, logic [7:0] handle);
    status_t     st;
    logic [15:0] limit;
    logic [3:0]  tries_max;
    st = '{default: '0};
    case (op)
      OP_ENQUEUE: begin
        if (4'(wr_ptr - rd_ptr) >= 4'd8) begin
          rd_ptr         = wr_ptr;
          busy           = 1'b0;
          tries_done     = '0;
          ticks          = '0;
          st.result_code = RES_FULL;
        end else begin
          slots[wr_ptr[2:0]] = handle;
          wr_ptr             = wr_ptr + 4'd1;
          if (!busy) st.send_valid = launch_next();
        end
      end
      OP_SEND_DONE: st.send_valid = launch_next();
      OP_TICK: begin
        if (busy) begin
          limit     = (timeout_cfg == 0) ? 16'd1 : timeout_cfg;
          tries_max = (attempts_cfg == 0) ? 4'd1 : attempts_cfg;
          if (ticks < limit) ticks = ticks + 16'd1;
          if (ticks >= limit) begin
            if (tries_done < tries_max) begin
              tries_done   = tries_done + 4'd1;
              ticks        = '0;
              st.send_valid = 1'b1;
              st.is_resend  = 1'b1;
            end else begin
              st.result_code = RES_ABANDON;
              st.send_valid  = launch_next();
              if (!st.send_valid) begin
                tries_done = '0;
                ticks      = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    st.send_frame   = st.send_valid ? cur_frame : 8'd0;
    st.queue_level  = 4'(wr_ptr - rd_ptr);
    st.awaiting_ack = busy;
    return st;
  endfunction

  function automatic void compare_field(string fld, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, exp_v, act_v);
      err_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t st;
    if (!rst_ni) begin
      rd_ptr       = '0;
      wr_ptr       = '0;
      cur_frame    = '0;
      busy         = 1'b0;
      tries_done   = '0;
      ticks        = '0;
      timeout_cfg  = RST_ACK_TIMEOUT;
      attempts_cfg = RST_MAX_ATTEMPTS;
      status_due.delete();
      err_cnt_o    = 0;
      pending_o    = 0;
      beats_o      = 0;
      retries_o    = 0;
      abandons_o   = 0;
      overflows_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACK_TIMEOUT) timeout_cfg = cfg_data_i;
        else if (cfg_idx_i == CFG_MAX_ATTEMPTS) attempts_cfg = cfg_data_i[ATTEMPT_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        st = advance_link_state(s_axis_tdata[1:0], s_axis_tdata[9:2]);
        if (st.is_resend) retries_o++;
        if (st.result_code == RES_ABANDON) abandons_o++;
        if (st.result_code == RES_FULL) overflows_o++;
        status_due.push_back(st);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_o++;
        if (status_due.size() == 0) begin
          $display("%0t: unexpected status beat, expected none, actual %0h",
                   $time, m_axis_tdata);
          err_cnt_o++;
        end else begin
          st = status_due.pop_front();
          compare_field("send_valid", st.send_valid, m_axis_tdata[0]);
          compare_field("send_frame", st.send_frame, m_axis_tdata[8:1]);
          compare_field("is_resend", st.is_resend, m_axis_tdata[9]);
          compare_field("result_code", st.result_code, m_axis_tdata[11:10]);
          compare_field("queue_level", st.queue_level, m_axis_tdata[15:12]);
          compare_field("awaiting_ack", st.awaiting_ack, m_axis_tdata[16]);
        end
      end
      pending_o = status_due.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// stimulus and verdict for the send queue with ack retry
`timescale 1ns / 1ps
module tb;
  import sqar_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam int              IDLE_LIMIT = 4000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;

  int err_cnt, pending, beats, retries, abandons, overflows;
  int idle_cycles;
  int phases;
  bit no_gaps;

  send_queue_ack_retry u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sqar_status_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending),
    .beats_o       (beats),
    .retries_o     (retries),
    .abandons_o    (abandons),
    .overflows_o   (overflows)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // status side back-pressure
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = pick_gap();
      if (stall == 0) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  task automatic send_event(logic [OP_W-1:0] op, logic [7:0] handle);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, handle, op};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_status();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] timeout, logic [3:0] attempts);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_ACK_TIMEOUT;
    cfg_data_i = timeout;
    @(negedge clk_i);
    cfg_idx_i  = CFG_MAX_ATTEMPTS;
    cfg_data_i = {12'd0, attempts};
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    phases++;
  endtask

  task automatic random_events(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_event(OP_ENQUEUE, 8'($urandom_range(0, 255)));
      else if (r < 55) send_event(OP_SEND_DONE, 8'($urandom_range(0, 255)));
      else if (r < 96) send_event(OP_TICK, 8'($urandom_range(0, 255)));
      else send_event(OP_UNUSED, 8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("send_queue_ack_retry test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_gaps       = 1'b0;
    phases        = 1;
    idle_cycles   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle corner cases, retries up to the attempt limit, then overflow
    send_event(OP_TICK, 8'h00);
    send_event(OP_SEND_DONE, 8'h00);
    send_event(OP_UNUSED, 8'hFF);
    send_event(OP_ENQUEUE, 8'h00);
    send_event(OP_ENQUEUE, 8'hFF);
    repeat (15) send_event(OP_TICK, 8'h00);
    for (int i = 0; i < 9; i++) send_event(OP_ENQUEUE, 8'(8'h11 * i));
    drain_status();

    // zero timeout and zero attempts act as one
    write_regs(16'd0, 4'd0);
    send_event(OP_ENQUEUE, 8'hA5);
    send_event(OP_TICK, 8'h5A);
    drain_status();

    write_regs(16'd1, 4'd1);
    no_gaps = 1'b1;
    random_events(110);
    drain_status();
    write_regs(16'd2, 4'd15);
    no_gaps = 1'b0;
    random_events(130);
    drain_status();
    write_regs(16'hFFFF, 4'hF);
    random_events(40);
    drain_status();
    write_regs(16'd3, 4'd2);
    random_events(130);
    drain_status();
    write_regs(16'd0, 4'd0);
    no_gaps = 1'b1;
    random_events(90);
    drain_status();
    write_regs(16'($urandom_range(1, 6)), 4'($urandom_range(1, 15)));
    no_gaps = 1'b0;
    random_events(170);
    drain_status();
    repeat (10) @(posedge clk_i);

    $display("checked %0d status beats over %0d register settings", beats, phases);
    $display("saw %0d retries, %0d abandoned frames and %0d queue overflows",
             retries, abandons, overflows);
    if (err_cnt == 0 && pending == 0) begin
      $display("send_queue_ack_retry test passed");
    end else begin
      $display("send_queue_ack_retry test failed");
    end
    $finish;
  end

endmodule
